### src/integer_alu_64_signed_unsigned_defines.svh
// Assertion macros shared by the ALU checker.
`ifndef INTEGER_ALU_64_SIGNED_UNSIGNED_DEFINES_SVH
`define INTEGER_ALU_64_SIGNED_UNSIGNED_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define IALU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ialu check failed");
// Next-cycle implication checked outside reset.
`define IALU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ialu check failed");
`endif

### src/ialu_pkg.sv
// Package with ALU operation codes, widths and shared types.
`timescale 1ns / 1ps
package ialu_pkg;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned FieldWidth = 64;
  localparam int unsigned ModeWidth = 4;

  typedef enum logic [ModeWidth-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_REM = 4'd4,
    OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7, OP_SHL = 4'd8, OP_SHR = 4'd9,
    OP_GT = 4'd10, OP_LT = 4'd11, OP_EQ = 4'd12
  } op_e;

  // Control that travels alongside the data through the cell chain.
  typedef struct packed {
    logic         valid;
    logic [ModeWidth-1:0] mode;
    logic         sgn;
    logic         neg_q;
    logic         neg_r;
    logic         zero_div;
  } ctl_t;
endpackage

### src/ialu_if.sv
// Valid/ready channel interfaces for ALU operands and results.
`timescale 1ns / 1ps
interface ialu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic        signed_ops;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, mode, signed_ops, operand_a, operand_b, input ready);
  modport sink (input valid, mode, signed_ops, operand_a, operand_b, output ready);
endinterface

interface ialu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic        zero_divisor;
  modport source (output valid, result_value, zero_divisor, input ready);
  modport sink (input valid, result_value, zero_divisor, output ready);
endinterface

### src/integer_alu_64_signed_unsigned.sv
// Top level of the pipelined 64-bit signed/unsigned integer ALU.
//
//  channel | dir | payload                                     | handshake
//  in_ch   | in  | mode, signed_ops, operand_a, operand_b       | valid/ready
//  out_ch  | out | result_value, zero_divisor                  | valid/ready
//
// One transaction is accepted per cycle while the output register is empty or taken.
// Its result passes through the chain of DATA_WIDTH division cells, one quotient
// bit per cell, followed by the output register. Every operation runs down the
// same chain, so results keep their order. The whole chain advances only when
// the output register is empty or taken, so a stall on the output freezes it
// with nothing lost. Reset is asynchronous, active low, and clears all valid flags.
`timescale 1ns / 1ps
module integer_alu_64_signed_unsigned #(
  parameter int unsigned DATA_WIDTH = ialu_pkg::DataWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  ialu_in_if.sink    in_ch,
  ialu_out_if.source out_ch
);
  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned FW = ialu_pkg::FieldWidth;

  // The pipeline moves when the output slot is free or being drained.
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 0: operand conditioning and all operations other than multiply, divide and remainder.
  logic [W-1:0] a, b, ma, mb, simple;
  logic [5:0]   sh;
  logic         na, nb, lt_s, gt_s;
  ialu_pkg::ctl_t ctl0;
  logic [W:0]   sra;

  always_comb begin
    a  = in_ch.operand_a[W-1:0];
    b  = in_ch.operand_b[W-1:0];
    sh = in_ch.operand_b[5:0];
    na = in_ch.signed_ops && a[W-1];
    nb = in_ch.signed_ops && b[W-1];
    ma = na ? W'(-a) : a;
    mb = nb ? W'(-b) : b;
    lt_s = ({a[W-1] ^ in_ch.signed_ops, a[W-2:0]} < {b[W-1] ^ in_ch.signed_ops, b[W-2:0]});
    gt_s = ({a[W-1] ^ in_ch.signed_ops, a[W-2:0]} > {b[W-1] ^ in_ch.signed_ops, b[W-2:0]});
    sra  = $signed({na, a}) >>> sh;
    simple = '0;
    case (ialu_pkg::op_e'(in_ch.mode))
      ialu_pkg::OP_ADD: simple = a + b;
      ialu_pkg::OP_SUB: simple = a - b;
      ialu_pkg::OP_AND: simple = a & b;
      ialu_pkg::OP_OR:  simple = a | b;
      ialu_pkg::OP_XOR: simple = a ^ b;
      ialu_pkg::OP_SHL: simple = (32'(sh) >= W) ? '0 : (a << sh);
      ialu_pkg::OP_SHR: simple = (32'(sh) >= W) ? {W{na}} : sra[W-1:0];
      ialu_pkg::OP_GT:  simple = W'(gt_s);
      ialu_pkg::OP_LT:  simple = W'(lt_s);
      ialu_pkg::OP_EQ:  simple = W'(a == b);
      default:          simple = '0;
    endcase
    ctl0.valid    = in_ch.valid;
    ctl0.mode     = in_ch.mode;
    ctl0.sgn      = in_ch.signed_ops;
    ctl0.neg_q    = na ^ nb;
    ctl0.neg_r    = na;
    ctl0.zero_div = (b == '0);
  end

  // Multiplier runs beside the chain; its product is parked in the carried
  // result word once the pipeline reaches the matching stage.
  logic [W-1:0] prod;
  ialu_mul #(.W(W)) u_mul (
    .clk_i(clk_i), .en_i(adv), .a_i(a), .b_i(b), .p_o(prod)
  );

  // Chain of division cells.
  ialu_pkg::ctl_t ctl [W+1];
  logic [W-1:0] rem [W+1];
  logic [W-1:0] quo [W+1];
  logic [W-1:0] dvs [W+1];
  logic [W-1:0] res [W+1];

  assign ctl[0] = ctl0;
  assign rem[0] = '0;
  assign quo[0] = ma;
  assign dvs[0] = mb;
  assign res[0] = simple;

  for (genvar i = 0; i < W; i++) begin : g_cell
    logic [W-1:0] res_in;
    // The product leaves the multiplier's two register stages as the item reaches cell 2's input.
    if (i == 2) begin : g_mul_tap
      assign res_in = (ctl[i].mode == ialu_pkg::OP_MUL) ? prod : res[i];
    end else begin : g_pass
      assign res_in = res[i];
    end
    ialu_cell #(.W(W)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
      .ctl_i(ctl[i]), .rem_i(rem[i]), .quo_i(quo[i]), .div_i(dvs[i]), .res_i(res_in),
      .ctl_o(ctl[i+1]), .rem_o(rem[i+1]), .quo_o(quo[i+1]), .div_o(dvs[i+1]),
      .res_o(res[i+1])
    );
  end

  // Final stage: sign fix-up and result selection into the output register.
  ialu_pkg::ctl_t cl;
  logic [W-1:0] fin, q_fix, r_fix;
  logic         zd;
  logic [W-1:0] res_q;
  logic         zd_q;

  always_comb begin
    cl    = ctl[W];
    q_fix = cl.neg_q ? W'(-quo[W]) : quo[W];
    r_fix = cl.neg_r ? W'(-rem[W]) : rem[W];
    zd    = 1'b0;
    case (ialu_pkg::op_e'(cl.mode))
      ialu_pkg::OP_DIV: begin
        zd  = cl.zero_div;
        fin = cl.zero_div ? '0 : q_fix;
      end
      ialu_pkg::OP_REM: begin
        zd  = cl.zero_div;
        fin = cl.zero_div ? '0 : r_fix;
      end
      default: fin = res[W];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= fin;
      zd_q  <= zd;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.result_value = FW'(res_q);
  assign out_ch.zero_divisor = zd_q;
endmodule

### src/ialu_cell.sv
// One restoring-division cell: retires one quotient bit and passes its work on.
`timescale 1ns / 1ps
module ialu_cell #(
  parameter int unsigned W = ialu_pkg::DataWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  ialu_pkg::ctl_t  ctl_i,
  input  logic [W-1:0]    rem_i,
  input  logic [W-1:0]    quo_i,
  input  logic [W-1:0]    div_i,
  input  logic [W-1:0]    res_i,
  output ialu_pkg::ctl_t  ctl_o,
  output logic [W-1:0]    rem_o,
  output logic [W-1:0]    quo_o,
  output logic [W-1:0]    div_o,
  output logic [W-1:0]    res_o
);
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] rem_d, quo_d;

  always_comb begin
    trial = {rem_i, quo_i[W-1]};
    diff  = trial - {1'b0, div_i};
    if (!diff[W]) begin
      rem_d = diff[W-1:0];
      quo_d = {quo_i[W-2:0], 1'b1};
    end else begin
      rem_d = trial[W-1:0];
      quo_d = {quo_i[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      quo_o <= quo_d;
      div_o <= div_i;
      res_o <= res_i;
    end
  end
endmodule

### src/ialu_mul.sv
// Multiplier pipeline built from 32x32 partial products, modulo 2^W result.
`timescale 1ns / 1ps
module ialu_mul #(
  parameter int unsigned W = ialu_pkg::DataWidth
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] p_o
);
  localparam int unsigned H = (W + 1) / 2;
  localparam int unsigned L = W - H;
  logic [2*H-1:0] ll_q, lh_q, hl_q;
  logic [H-1:0] al, bl;
  logic [H-1:0] ah, bh;
  logic [2*H-1:0] sum;

  always_comb begin
    al = a_i[H-1:0];
    bl = b_i[H-1:0];
    ah = '0;
    bh = '0;
    ah[L-1:0] = a_i[W-1:H];
    bh[L-1:0] = b_i[W-1:H];
    sum = ll_q + {lh_q[H-1:0] + hl_q[H-1:0], {H{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= al * bl;
      lh_q <= al * bh;
      hl_q <= ah * bl;
      p_o  <= sum[W-1:0];
    end
  end
endmodule

### src/ialu_checker.sv
// Port-level checker for the ALU, bound to the top level.
`timescale 1ns / 1ps
`include "integer_alu_64_signed_unsigned_defines.svh"
module ialu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [63:0] result_value_i,
  input logic zero_divisor_i
);
  `IALU_ASSERT_IMP(a_zd_zero, clk_i, rst_ni, out_valid_i && zero_divisor_i, result_value_i == 64'd0)
  `IALU_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i)
  `IALU_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)
  `IALU_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(result_value_i))
endmodule

bind integer_alu_64_signed_unsigned ialu_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .result_value_i(out_ch.result_value), .zero_divisor_i(out_ch.zero_divisor)
);

### tb/tb.sv
// Self-checking testbench for the pipelined 64-bit signed/unsigned integer ALU.
`timescale 1ns / 1ps
module tb;

  // One expected ALU answer, held until the matching output transaction.
  typedef struct {
    logic [63:0] value;
    logic        zero_div;
  } alu_answer_t;

  // Scoreboard: computes the answer for each accepted operation and
  // compares the results that leave the block, oldest first.
  class alu_scoreboard;
    alu_answer_t pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Work out the answer for one accepted operation and queue it.
    function void note_operation(logic [3:0] mode, logic sgn, logic [63:0] a,
                                 logic [63:0] b);
      alu_answer_t ans;
      logic [63:0] ma, mb, q, m;
      logic        na, nb;
      int unsigned sh;
      ans.value = '0;
      ans.zero_div = 1'b0;
      sh = 32'(b[5:0]);
      na = sgn & a[63];
      nb = sgn & b[63];
      ma = na ? -a : a;
      mb = nb ? -b : b;
      case (mode)
        ialu_pkg::OP_ADD: ans.value = a + b;
        ialu_pkg::OP_SUB: ans.value = a - b;
        ialu_pkg::OP_MUL: ans.value = a * b;
        ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
          if (b == 64'd0) begin
            ans.zero_div = 1'b1;
          end else if (mode == ialu_pkg::OP_DIV) begin
            q = ma / mb;
            ans.value = (na != nb) ? -q : q;
          end else begin
            m = ma % mb;
            ans.value = na ? -m : m;
          end
        end
        ialu_pkg::OP_AND: ans.value = a & b;
        ialu_pkg::OP_OR:  ans.value = a | b;
        ialu_pkg::OP_XOR: ans.value = a ^ b;
        ialu_pkg::OP_SHL: ans.value = a << sh;
        ialu_pkg::OP_SHR: ans.value = na ? ~((~a) >> sh) : (a >> sh);
        ialu_pkg::OP_GT:  ans.value = sgn ? 64'($signed(a) > $signed(b)) : 64'(a > b);
        ialu_pkg::OP_LT:  ans.value = sgn ? 64'($signed(a) < $signed(b)) : 64'(a < b);
        ialu_pkg::OP_EQ:  ans.value = 64'(a == b);
        default: ans.value = '0;
      endcase
      pending.push_back(ans);
    endfunction

    // Compare one result transaction with the oldest pending answer.
    function void check_result(logic [63:0] value, logic zero_div);
      alu_answer_t ans;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h zero_divisor=%b", $time, value, zero_div);
        errors++;
        return;
      end
      ans = pending.pop_front();
      if (value !== ans.value) begin
        $display("%0t: result_value expected %h actual %h", $time, ans.value, value);
        errors++;
      end
      if (zero_div !== ans.zero_div) begin
        $display("%0t: zero_divisor expected %b actual %b", $time, ans.zero_div, zero_div);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned RandomOps = 1100;
  localparam int unsigned Latency = 66;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  ialu_in_if  in_ch();
  ialu_out_if out_ch();

  alu_scoreboard board;
  logic          stim_done;
  longint unsigned cycle_count;

  integer_alu_64_signed_unsigned uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A random 64-bit operand that favors edge patterns and small values.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'($urandom_range(0, 70));
      5: return -64'($urandom_range(1, 70));
      6: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Present one operation and hold it until the block takes it.
  // Valid drops only across a gap, so back-to-back operations keep it high.
  task automatic send_op(logic [3:0] mode, logic sgn, logic [63:0] a, logic [63:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.signed_ops <= sgn;
    in_ch.operand_a  <= a;
    in_ch.operand_b  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_operation(mode, sgn, a, b);
  endtask

  // Directed corners, then random operations, then drain.
  initial begin
    logic [63:0] a, b;
    int unsigned k;
    board = new();
    stim_done = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.signed_ops = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Each operation in unsigned mode on extreme operands.
    for (int op = 0; op <= 12; op++) begin
      send_op(4'(op), 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
    end
    // Zero divisor, most negative over minus one, wide shifts, unused codes.
    send_op(ialu_pkg::OP_DIV, 1'b1, 64'd55, 64'd0);
    send_op(ialu_pkg::OP_REM, 1'b0, 64'd55, 64'd0);
    send_op(ialu_pkg::OP_DIV, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(ialu_pkg::OP_REM, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(ialu_pkg::OP_DIV, 1'b1, -64'd7, 64'd2);
    send_op(ialu_pkg::OP_REM, 1'b1, -64'd7, 64'd2);
    send_op(ialu_pkg::OP_SHR, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC3);
    send_op(ialu_pkg::OP_SHL, 1'b0, 64'h0000_0000_0000_0001, 64'd63);
    send_op(ialu_pkg::OP_LT, 1'b1, 64'h8000_0000_0000_0000, 64'd1);
    send_op(4'd13, 1'b0, 64'd1, 64'd1);
    send_op(4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

    for (k = 0; k < RandomOps; k++) begin
      a = pick_operand();
      b = pick_operand();
      send_op(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), a, b);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random back-pressure, checking on every transaction.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.result_value, out_ch.zero_divisor);
      end
    end
  end

  // Run control: wait for the drain, allow the pipeline to settle, report.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done === 1'b1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
